### hw/rtl/tgbl_pkg.sv
// package of constants and types for the terrain grid bilinear lookup
package tgbl_pkg;

    localparam int DEF_ROWS    = 28;
    localparam int DEF_COLS    = 32;
    localparam int DEF_SUBGRID = 4;

    localparam int ROW_IN_W  = 5;
    localparam int COL_IN_W  = 5;
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_W    = 16;
    localparam int HEIGHT_W  = 32;
    localparam int BITMAP_W  = 56;
    localparam int COORD_W   = 7;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 40;
    localparam int CFG_IDX_W = 1;

    localparam int FIFO_DEPTH = 8;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_COVERAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOADED   = 1'd1;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height_q16;
        logic                ok;
    } result_t;

endpackage

### hw/rtl/terrain_grid_bilinear_lookup.sv
// top level of the terrain grid bilinear lookup
//
// One terrain block of ROWS x COLS signed 16-bit heights sits in four ram
// banks split by row and column parity, so the four corners of a query are
// read in the same cycle, one from each bank.
// Input stream (s_): tuser is the kind, 0 writes one height, 1 queries.
// Result stream (m_): one result per input transfer, in input order.
// Configuration: cfg_wr_en with cfg_index 0 writes the coverage bitmap,
// index 1 the block-loaded flag; write only while the block is idle.
// A result passes the north multiply, north blend, east multiply and final
// add stages into an 8-entry output fifo before it is offered.
// Throughput: one item per cycle; s_tready drops once 8 items are
// outstanding, which only happens while the receiver stalls m_tready.
// While stalled the pipeline keeps running into the fifo, no data is lost.
// Reset clears the coverage bitmap, the loaded flag, the pipeline and the
// fifo and holds s_tready low; heights are undefined until written and need
// no clearing pass.
module terrain_grid_bilinear_lookup
    import tgbl_pkg::*;
#(
    parameter int ROWS    = DEF_ROWS,
    parameter int COLS    = DEF_COLS,
    parameter int SUBGRID = DEF_SUBGRID
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BITMAP_W-1:0]  cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // row[4:0] col[9:5] sample[25:10] frac_north[41:26] frac_east[57:42]
    input  logic [S_DATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic                 s_tuser,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // ok[0] height_q16[32:1]
    output logic [M_DATA_W-1:0]  m_tdata
);

    localparam int RW         = $clog2(ROWS);
    localparam int CW         = $clog2(COLS);
    localparam int HROWS      = (ROWS + 1) / 2;
    localparam int HCOLS      = (COLS + 1) / 2;
    localparam int HR_W       = $clog2(HROWS);
    localparam int HC_W       = $clog2(HCOLS);
    localparam int AW         = HR_W + HC_W;
    localparam int BANK_DEPTH = HROWS * (2 ** HC_W);
    localparam int SUB_ROWS   = ROWS / SUBGRID;
    localparam int BIT_MAX    = ((COLS - 1) / SUBGRID) * SUB_ROWS + (ROWS - 1) / SUBGRID;
    localparam int BIT_W      = (BIT_MAX < 1) ? 1 : $clog2(BIT_MAX + 1);
    localparam int COV_N      = 2 ** BIT_W;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int P2_W       = HEIGHT_W + 1 + FRAC_W + 1;

    // configuration
    logic [BITMAP_W-1:0] coverage_reg;
    logic                loaded_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coverage_reg <= '0;
            loaded_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_COVERAGE) begin
                coverage_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_LOADED) begin
                loaded_reg <= cfg_wdata[0];
            end
        end
    end

    // input fields
    logic [ROW_IN_W-1:0] s_row;
    logic [COL_IN_W-1:0] s_col;
    logic [SAMPLE_W-1:0] s_sample;
    logic [FRAC_W-1:0]   s_frac_north;
    logic [FRAC_W-1:0]   s_frac_east;
    logic                in_xfer;
    logic                out_xfer;

    assign s_row        = s_tdata[4:0];
    assign s_col        = s_tdata[9:5];
    assign s_sample     = s_tdata[25:10];
    assign s_frac_north = s_tdata[41:26];
    assign s_frac_east  = s_tdata[57:42];

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // coordinates, clamping and coverage
    logic [COORD_W-1:0] r_in, c_in, r_c, c_c, r1, c1;
    logic               wr_ok;

    assign r_in  = {{(COORD_W - ROW_IN_W){1'b0}}, s_row};
    assign c_in  = {{(COORD_W - COL_IN_W){1'b0}}, s_col};
    assign r_c   = (r_in > COORD_W'(ROWS - 2)) ? COORD_W'(ROWS - 2) : r_in;
    assign c_c   = (c_in > COORD_W'(COLS - 2)) ? COORD_W'(COLS - 2) : c_in;
    assign r1    = r_c + 1'b1;
    assign c1    = c_c + 1'b1;
    assign wr_ok = (r_in < COORD_W'(ROWS)) && (c_in < COORD_W'(COLS));

    logic [BIT_W-1:0] row_bit [ROWS];
    logic [BIT_W-1:0] col_bit [COLS];
    logic [COV_N-1:0] cov_ext;

    for (genvar g = 0; g < ROWS; g++) begin : g_row_bit
        assign row_bit[g] = BIT_W'(g / SUBGRID);
    end
    for (genvar g = 0; g < COLS; g++) begin : g_col_bit
        assign col_bit[g] = BIT_W'((g / SUBGRID) * SUB_ROWS);
    end
    for (genvar g = 0; g < COV_N; g++) begin : g_cov
        if (g < BITMAP_W) begin : g_in
            assign cov_ext[g] = coverage_reg[g];
        end else begin : g_out
            assign cov_ext[g] = 1'b0;
        end
    end

    logic [BIT_W-1:0] bit00, bit01, bit10, bit11;
    logic             all_cov;
    logic             ok_s0;

    assign bit00   = row_bit[r_c[RW-1:0]] + col_bit[c_c[CW-1:0]];
    assign bit01   = row_bit[r_c[RW-1:0]] + col_bit[c1[CW-1:0]];
    assign bit10   = row_bit[r1[RW-1:0]] + col_bit[c_c[CW-1:0]];
    assign bit11   = row_bit[r1[RW-1:0]] + col_bit[c1[CW-1:0]];
    assign all_cov = cov_ext[bit00] && cov_ext[bit01] && cov_ext[bit10] && cov_ext[bit11];
    assign ok_s0   = (s_tuser == KIND_QUERY) ? (loaded_reg && all_cov) : wr_ok;

    // banked height store
    logic          wr_fire;
    logic [1:0]    wr_bank;
    logic [AW-1:0] wr_addr;
    logic [3:0]    bank_we;
    logic [SAMPLE_W-1:0] rd_data [4];

    assign wr_fire = in_xfer && (s_tuser == KIND_WRITE) && wr_ok;
    assign wr_bank = {r_in[0], c_in[0]};
    assign wr_addr = {r_in[HR_W:1], c_in[HC_W:1]};

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PR = 1'(b / 2);
        localparam logic PC = 1'(b % 2);
        logic [COORD_W-1:0] q_row, q_col;
        logic [AW-1:0]      q_addr;

        assign q_row      = (r_c[0] == PR) ? r_c : r1;
        assign q_col      = (c_c[0] == PC) ? c_c : c1;
        assign q_addr     = {q_row[HR_W:1], q_col[HC_W:1]};
        assign bank_we[b] = wr_fire && (wr_bank == 2'(b));

        tgbl_ram #(
            .WIDTH(SAMPLE_W),
            .DEPTH(BANK_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (bank_we[b]),
            .waddr (wr_addr),
            .wdata (s_sample),
            .raddr (q_addr),
            .rdata (rd_data[b])
        );
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ok1_reg, ok2_reg, ok3_reg, ok4_reg;
    logic q1_reg, q2_reg, q3_reg, q4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= in_xfer;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 1: corners from the banks, first multiplies
    logic                pr1_reg, pc1_reg;
    logic [FRAC_W-1:0]   fn1_reg, fe1_reg, fe2_reg, fe3_reg;
    logic signed [SAMPLE_W-1:0] h00, h01, h10, h11;
    logic signed [SAMPLE_W:0]   da, db;
    logic signed [2*SAMPLE_W+1:0] pa_next, pb_next;

    assign h00 = $signed(rd_data[{pr1_reg, pc1_reg}]);
    assign h01 = $signed(rd_data[{pr1_reg, ~pc1_reg}]);
    assign h10 = $signed(rd_data[{~pr1_reg, pc1_reg}]);
    assign h11 = $signed(rd_data[{~pr1_reg, ~pc1_reg}]);
    assign da  = {h10[SAMPLE_W-1], h10} - {h00[SAMPLE_W-1], h00};
    assign db  = {h11[SAMPLE_W-1], h11} - {h01[SAMPLE_W-1], h01};
    assign pa_next = da * $signed({1'b0, fn1_reg});
    assign pb_next = db * $signed({1'b0, fn1_reg});

    // stage 2: north blends and their difference
    logic signed [2*SAMPLE_W+1:0] pa2_reg, pb2_reg;
    logic signed [SAMPLE_W-1:0]   h00_2_reg, h01_2_reg;
    logic signed [2*SAMPLE_W+1:0] a_full, b_full;
    logic signed [HEIGHT_W:0]     diff_next;

    assign a_full = $signed({{2{h00_2_reg[SAMPLE_W-1]}}, h00_2_reg, 16'b0}) + pa2_reg;
    assign b_full = $signed({{2{h01_2_reg[SAMPLE_W-1]}}, h01_2_reg, 16'b0}) + pb2_reg;
    assign diff_next = $signed({b_full[HEIGHT_W-1], b_full[HEIGHT_W-1:0]})
                     - $signed({a_full[HEIGHT_W-1], a_full[HEIGHT_W-1:0]});

    // stage 3: east multiply
    logic signed [HEIGHT_W-1:0] a3_reg, a4_reg;
    logic signed [HEIGHT_W:0]   diff3_reg;
    logic signed [P2_W-1:0]     p_next, p4_reg;

    assign p_next = diff3_reg * $signed({1'b0, fe3_reg});

    // stage 4: floor add
    logic signed [P2_W-1:0] sum4;
    result_t                res_next;

    assign sum4 = $signed({{(P2_W - HEIGHT_W){a4_reg[HEIGHT_W-1]}}, a4_reg}) + (p4_reg >>> 16);
    assign res_next.ok         = ok4_reg;
    assign res_next.height_q16 = q4_reg ? sum4[HEIGHT_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        ok1_reg   <= ok_s0;
        q1_reg    <= (s_tuser == KIND_QUERY) && ok_s0;
        pr1_reg   <= r_c[0];
        pc1_reg   <= c_c[0];
        fn1_reg   <= s_frac_north;
        fe1_reg   <= s_frac_east;

        ok2_reg   <= ok1_reg;
        q2_reg    <= q1_reg;
        fe2_reg   <= fe1_reg;
        pa2_reg   <= pa_next;
        pb2_reg   <= pb_next;
        h00_2_reg <= h00;
        h01_2_reg <= h01;

        ok3_reg   <= ok2_reg;
        q3_reg    <= q2_reg;
        fe3_reg   <= fe2_reg;
        a3_reg    <= a_full[HEIGHT_W-1:0];
        diff3_reg <= diff_next;

        ok4_reg   <= ok3_reg;
        q4_reg    <= q3_reg;
        a4_reg    <= a3_reg;
        p4_reg    <= p_next;
    end

    // output fifo and outstanding count
    result_t         fifo_mem_reg [FIFO_DEPTH];
    logic [FP_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FP_W:0]   fifo_cnt_reg, fifo_cnt_next;
    logic [FP_W:0]   inflight_reg, inflight_next;

    assign fifo_cnt_next = fifo_cnt_reg + (FP_W + 1)'(v4_reg) - (FP_W + 1)'(out_xfer);
    assign inflight_next = inflight_reg + (FP_W + 1)'(in_xfer) - (FP_W + 1)'(out_xfer);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            inflight_reg <= '0;
        end else begin
            if (v4_reg) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_xfer) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_next;
            inflight_reg <= inflight_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (v4_reg) begin
            fifo_mem_reg[wr_ptr_reg] <= res_next;
        end
    end

    assign s_tready = aresetn && (inflight_reg < (FP_W + 1)'(FIFO_DEPTH));
    assign m_tvalid = fifo_cnt_reg != '0;
    assign m_tdata  = {{(M_DATA_W - HEIGHT_W - 1){1'b0}}, fifo_mem_reg[rd_ptr_reg]};

`ifndef SYNTHESIS
    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= (FP_W + 1)'(FIFO_DEPTH))
        else $error("outstanding item count above fifo depth");

    a_fifo_within_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= inflight_reg)
        else $error("fifo holds more results than outstanding items");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (fifo_cnt_reg != (FP_W + 1)'(FIFO_DEPTH)) || out_xfer)
        else $error("result pushed into a full fifo");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[HEIGHT_W:1] == '0))
        else $error("failed result with nonzero height");

    a_write_no_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (s_tuser == KIND_WRITE)) |=> !q1_reg)
        else $error("write item marked for interpolation");
`endif

endmodule

### hw/rtl/tgbl_ram.sv
// generic single-write, single-read ram with registered read data
module tgbl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
